/* rtl/lrgd_pkg.sv */
package lrgd_pkg;

   // default sizes of the sample store and the data path
   localparam int unsigned MAX_SAMPLES_DEF = 256;
   localparam int unsigned DATA_WIDTH_DEF  = 32;

   // fixed widths of the port fields and the accumulators
   localparam int unsigned FIELD_W   = 32;
   localparam int unsigned FRAC_BITS = 16;
   localparam int unsigned ESUM_W    = 48;
   localparam int unsigned WSUM_W    = 64;
   localparam int unsigned RATE_W    = 16;
   localparam int unsigned EPOCH_W   = 16;
   localparam int unsigned CSR_IDX_W = 4;

   // register reset values
   localparam logic [EPOCH_W-1:0] EPOCH_RESET = EPOCH_W'(500);
   localparam logic [RATE_W-1:0]  RATE_RESET  = RATE_W'(1311);

   // largest step magnitude added to a coefficient
   localparam logic [WSUM_W-1:0] STEP_LIMIT = WSUM_W'(64'h4000_0000_0000_0000);

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_EPOCH_COUNT    = 4'd0,
      CSR_LEARNING_RATE  = 4'd1,
      CSR_INIT_SLOPE     = 4'd2,
      CSR_INIT_INTERCEPT = 4'd3
   } csr_index_type;

endpackage

/* rtl/linear_regression_gradient_descent.sv */
// Simple linear regression trained by batch gradient descent, signed Q16.16.
// Input channel (req_): one (x, y) sample word per cycle goes into the sample
// store while req_ready is high. A word with req_last_sample set closes the
// set and starts training; req_ready then stays low until the run ends.
// A sample that arrives with the store full is dropped, but its last flag
// still starts training.
// Training runs epoch_count epochs. Each epoch streams the stored samples out
// of the store memory through a five-stage multiply/accumulate pipe, then
// computes the intercept step and the slope step in turn on one shared unit:
// a shift-add multiply by the rate and a restoring divide by n. epoch_count 0
// returns the initial values.
// Result channel (rsp_): one word (slope, intercept) per set, held in an output
// register until taken. A stalled receiver lets the next set load; only the
// end of that next run waits for the register to free up.
// Configuration (csr_): always ready; write only while no run is in progress.
// Reset: empties the store and loads the register defaults.
module linear_regression_gradient_descent
   import lrgd_pkg::*;
#(
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
   parameter int DATA_WIDTH  = DATA_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [FIELD_W-1:0]   req_sample_x,
   input  logic [FIELD_W-1:0]   req_sample_y,
   input  logic                 req_last_sample,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [FIELD_W-1:0]   rsp_slope,
   output logic [FIELD_W-1:0]   rsp_intercept,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [FIELD_W-1:0]   csr_wdata
);

   localparam int W     = DATA_WIDTH;
   localparam int AW    = $clog2(MAX_SAMPLES);
   localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
   localparam logic signed [64:0] COEF_MAX = (65'sd1 <<< (W - 1)) - 65'sd1;
   localparam logic signed [64:0] COEF_MIN = -COEF_MAX - 65'sd1;

   typedef enum logic [2:0] {
      ST_LOAD, ST_RUN, ST_PREP, ST_MUL, ST_DIV, ST_UPD, ST_DONE
   } state_type;

   state_type state_ff;

   // configuration registers
   logic [EPOCH_W-1:0]  epoch_cnt_ff;
   logic [RATE_W-1:0]   rate_ff;
   logic signed [W-1:0] init_slope_ff;
   logic signed [W-1:0] init_icpt_ff;

   // control
   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    n_ff;
   logic [CNT_W-1:0]    rd_idx_ff;
   logic [EPOCH_W-1:0]  epoch_ff;
   logic                sel_ff;
   logic                v1_ff, va_ff, vb_ff, vc_ff, vd_ff;
   logic [3:0]          bit_ff;
   logic [5:0]          dcnt_ff;
   logic                rsp_valid_ff;
   logic [FIELD_W-1:0]  rsp_slope_ff;
   logic [FIELD_W-1:0]  rsp_icpt_ff;
   logic signed [W-1:0] slope_ff;
   logic signed [W-1:0] icpt_ff;

   // data path
   logic signed [2*W-1:0]       p1_ff;
   logic signed [W-1:0]         xa_ff, ya_ff, xb_ff;
   logic signed [ESUM_W-1:0]    err_ff;
   logic signed [32+W-1:0]      pph_ff;
   logic signed [17+W-1:0]      ppl_ff;
   logic signed [WSUM_W-1:0]    term_ff;
   logic signed [ESUM_W-1:0]    esum_ff;
   logic signed [WSUM_W-1:0]    wsum_ff;
   logic                        neg_ff;
   logic [WSUM_W-1:0]           mag_ff;
   logic [WSUM_W+RATE_W-1:0]    acc_ff;
   logic [WSUM_W-1:0]           num_ff;
   logic [WSUM_W-1:0]           quo_ff;
   logic [CNT_W-1:0]            rem_ff;

   logic                req_fire, store_en, issue_en, pipe_busy, sums_clear;
   logic [CNT_W-1:0]    n_in;
   logic [2*W-1:0]      rd_data;
   logic signed [W-1:0] x_rd, y_rd;

   assign req_ready = (state_ff == ST_LOAD);
   assign csr_ready = 1'b1;
   assign req_fire  = req_valid && req_ready;
   assign store_en  = req_fire && (count_ff < CNT_W'(MAX_SAMPLES));
   assign n_in      = count_ff + CNT_W'(store_en);
   assign issue_en  = (state_ff == ST_RUN) && (rd_idx_ff < n_ff);
   assign pipe_busy = v1_ff || va_ff || vb_ff || vc_ff || vd_ff;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_slope     = rsp_slope_ff;
   assign rsp_intercept = rsp_icpt_ff;

   // sample store: x in the upper half, y in the lower half
   lrgd_ram #(
      .WIDTH (2 * W),
      .DEPTH (MAX_SAMPLES)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data ({req_sample_x[W-1:0], req_sample_y[W-1:0]}),
      .rd_addr (rd_idx_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   assign x_rd = $signed(rd_data[2*W-1:W]);
   assign y_rd = $signed(rd_data[W-1:0]);

   // error of one sample
   logic signed [63:0]       p1_ext;
   logic signed [ESUM_W-1:0] pred_w, err_w;
   assign p1_ext = 64'(p1_ff);
   assign pred_w = ESUM_W'(p1_ext >>> FRAC_BITS) + ESUM_W'(icpt_ff);
   assign err_w  = ESUM_W'(ya_ff) - pred_w;

   // saturating accumulations
   logic signed [ESUM_W:0]   es_sum;
   logic signed [ESUM_W-1:0] esum_in;
   logic signed [WSUM_W:0]   ws_sum;
   logic signed [WSUM_W-1:0] wsum_in;
   assign es_sum = (ESUM_W + 1)'(esum_ff) + (ESUM_W + 1)'(err_ff);
   assign ws_sum = (WSUM_W + 1)'(wsum_ff) + (WSUM_W + 1)'(term_ff);
   always_comb begin
      esum_in = es_sum[ESUM_W-1:0];
      if (es_sum[ESUM_W] != es_sum[ESUM_W-1]) begin
         esum_in = es_sum[ESUM_W] ? {1'b1, {(ESUM_W-1){1'b0}}} : {1'b0, {(ESUM_W-1){1'b1}}};
      end
      wsum_in = ws_sum[WSUM_W-1:0];
      if (ws_sum[WSUM_W] != ws_sum[WSUM_W-1]) begin
         wsum_in = ws_sum[WSUM_W] ? {1'b1, {(WSUM_W-1){1'b0}}} : {1'b0, {(WSUM_W-1){1'b1}}};
      end
   end

   // multiply/accumulate pipe over the stored samples
   always_ff @(posedge clock) begin
      p1_ff   <= x_rd * slope_ff;
      xa_ff   <= x_rd;
      ya_ff   <= y_rd;
      err_ff  <= err_w;
      xb_ff   <= xa_ff;
      pph_ff  <= $signed(err_ff[ESUM_W-1:FRAC_BITS]) * xb_ff;
      ppl_ff  <= $signed({1'b0, err_ff[FRAC_BITS-1:0]}) * xb_ff;
      term_ff <= 64'(pph_ff) + 64'(ppl_ff >>> FRAC_BITS);
      if (sums_clear) begin
         esum_ff <= '0;
         wsum_ff <= '0;
      end else begin
         if (vb_ff) begin
            esum_ff <= esum_in;
         end
         if (vd_ff) begin
            wsum_ff <= wsum_in;
         end
      end
   end

   // step unit: rate multiply, divide by n, clamp and add
   logic [WSUM_W+RATE_W-1:0] acc_in;
   logic [CNT_W:0]           trial;
   logic                     ge;
   logic [WSUM_W-1:0]        step_mag;
   logic signed [64:0]       step_val, coef_sum;
   logic signed [W-1:0]      coef_old, coef_in;
   logic signed [WSUM_W-1:0] step_src;

   assign acc_in   = {acc_ff[WSUM_W+RATE_W-2:0], 1'b0}
                     + (rate_ff[bit_ff] ? (WSUM_W + RATE_W)'(mag_ff) : '0);
   assign trial    = {rem_ff, num_ff[WSUM_W-1]};
   assign ge       = trial >= {1'b0, n_ff};
   assign step_mag = (quo_ff > STEP_LIMIT) ? STEP_LIMIT : quo_ff;
   assign step_val = neg_ff ? -$signed({1'b0, step_mag}) : $signed({1'b0, step_mag});
   assign coef_old = sel_ff ? slope_ff : icpt_ff;
   assign coef_sum = 65'(coef_old) + step_val;
   assign step_src = sel_ff ? wsum_ff : WSUM_W'(esum_ff);
   always_comb begin
      coef_in = coef_sum[W-1:0];
      if (coef_sum > COEF_MAX) begin
         coef_in = COEF_MAX[W-1:0];
      end else if (coef_sum < COEF_MIN) begin
         coef_in = COEF_MIN[W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_PREP: begin
            neg_ff <= step_src[WSUM_W-1];
            mag_ff <= step_src[WSUM_W-1] ? WSUM_W'(-step_src) : WSUM_W'(step_src);
            acc_ff <= '0;
         end
         ST_MUL: begin
            acc_ff <= acc_in;
            num_ff <= acc_in[WSUM_W+RATE_W-1:RATE_W];
            rem_ff <= '0;
            quo_ff <= '0;
         end
         ST_DIV: begin
            rem_ff <= ge ? CNT_W'(trial - {1'b0, n_ff}) : trial[CNT_W-1:0];
            quo_ff <= {quo_ff[WSUM_W-2:0], ge};
            num_ff <= {num_ff[WSUM_W-2:0], 1'b0};
         end
         default: begin
         end
      endcase
   end

   assign sums_clear = (req_fire && req_last_sample) || (state_ff == ST_UPD && sel_ff);

   // control: state, configuration, coefficients and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         epoch_cnt_ff  <= EPOCH_RESET;
         rate_ff       <= RATE_RESET;
         init_slope_ff <= '0;
         init_icpt_ff  <= '0;
         count_ff      <= '0;
         n_ff          <= '0;
         rd_idx_ff     <= '0;
         epoch_ff      <= '0;
         sel_ff        <= 1'b0;
         v1_ff         <= 1'b0;
         va_ff         <= 1'b0;
         vb_ff         <= 1'b0;
         vc_ff         <= 1'b0;
         vd_ff         <= 1'b0;
         bit_ff        <= '0;
         dcnt_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         rsp_slope_ff  <= '0;
         rsp_icpt_ff   <= '0;
         slope_ff      <= '0;
         icpt_ff       <= '0;
      end else begin
         // take register writes
         if (csr_valid) begin
            case (csr_index)
               CSR_EPOCH_COUNT:    epoch_cnt_ff  <= csr_wdata[EPOCH_W-1:0];
               CSR_LEARNING_RATE:  rate_ff       <= csr_wdata[RATE_W-1:0];
               CSR_INIT_SLOPE:     init_slope_ff <= csr_wdata[W-1:0];
               CSR_INIT_INTERCEPT: init_icpt_ff  <= csr_wdata[W-1:0];
               default: begin
               end
            endcase
         end

         // advance the sample pipe
         v1_ff <= issue_en;
         va_ff <= v1_ff;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
         vd_ff <= vc_ff;

         // drop the result once taken, unless a new one replaces it
         if (rsp_valid_ff && rsp_ready && state_ff != ST_DONE) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_LOAD: begin
               if (req_fire && req_last_sample) begin
                  n_ff      <= n_in;
                  count_ff  <= '0;
                  slope_ff  <= init_slope_ff;
                  icpt_ff   <= init_icpt_ff;
                  epoch_ff  <= '0;
                  rd_idx_ff <= '0;
                  state_ff  <= (epoch_cnt_ff == '0) ? ST_DONE : ST_RUN;
               end else if (store_en) begin
                  count_ff <= count_ff + CNT_W'(1);
               end
            end
            ST_RUN: begin
               if (issue_en) begin
                  rd_idx_ff <= rd_idx_ff + CNT_W'(1);
               end else if (!pipe_busy) begin
                  sel_ff   <= 1'b0;
                  state_ff <= ST_PREP;
               end
            end
            ST_PREP: begin
               bit_ff   <= 4'(RATE_W - 1);
               state_ff <= ST_MUL;
            end
            ST_MUL: begin
               bit_ff <= bit_ff - 4'd1;
               if (bit_ff == '0) begin
                  dcnt_ff  <= '0;
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               dcnt_ff <= dcnt_ff + 6'd1;
               if (dcnt_ff == 6'(WSUM_W - 1)) begin
                  state_ff <= ST_UPD;
               end
            end
            ST_UPD: begin
               if (!sel_ff) begin
                  icpt_ff  <= coef_in;
                  sel_ff   <= 1'b1;
                  state_ff <= ST_PREP;
               end else begin
                  slope_ff  <= coef_in;
                  epoch_ff  <= epoch_ff + EPOCH_W'(1);
                  rd_idx_ff <= '0;
                  state_ff  <= (epoch_ff + EPOCH_W'(1) == epoch_cnt_ff) ? ST_DONE : ST_RUN;
               end
            end
            ST_DONE: begin
               // hold until the output register is free
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_slope_ff <= FIELD_W'(slope_ff);
                  rsp_icpt_ff  <= FIELD_W'(icpt_ff);
                  state_ff     <= ST_LOAD;
               end
            end
            default: begin
               state_ff <= ST_LOAD;
            end
         endcase
      end
   end

endmodule

/* rtl/lrgd_ram.sv */
module lrgd_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write one entry, read one entry with a registered output
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/lrgd_checker.sv */
module lrgd_checker
   import lrgd_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               req_last_sample,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [FIELD_W-1:0] rsp_slope,
   input logic [FIELD_W-1:0] rsp_intercept
);

   // the last sample closes the input until the run ends
   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last_sample |=> !req_ready)
      else $error("input still open after last sample");

   // a new result only appears at the end of a run
   a_result_after_run: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result without a training run");

   // hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_slope) && $stable(rsp_intercept))
      else $error("result changed while stalled");

endmodule

bind linear_regression_gradient_descent lrgd_checker u_lrgd_checker (.*);

/* test/tb_gd_checker.sv */
`timescale 1ns / 1ps

module tb_gd_checker
   import lrgd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic [FIELD_W-1:0]   req_sample_x,
   input  logic [FIELD_W-1:0]   req_sample_y,
   input  logic                 req_last_sample,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic [FIELD_W-1:0]   rsp_slope,
   input  logic [FIELD_W-1:0]   rsp_intercept,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [FIELD_W-1:0]   csr_wdata,
   output int                   fail_count,
   output int                   fits_pending,
   output int                   fits_seen
);

   localparam int unsigned STORE_DEPTH = 256;
   localparam longint      ESUM_HI     = 64'sd140737488355327;
   localparam longint      ESUM_LO     = -ESUM_HI - 1;
   localparam longint      COEF_HI     = 64'sd2147483647;
   localparam longint      COEF_LO     = -COEF_HI - 1;

   typedef struct packed {
      logic [FIELD_W-1:0] slope;
      logic [FIELD_W-1:0] intercept;
   } fit_type;

   fit_type     fit_q[$];
   longint      x_held[STORE_DEPTH];
   longint      y_held[STORE_DEPTH];
   int unsigned held_count;
   logic [EPOCH_W-1:0] epochs_cfg;
   logic [RATE_W-1:0]  rate_cfg;
   longint      slope_start;
   longint      icpt_start;

   // floor(a*b / 2^16) on the exact product
   function automatic longint q16_product(longint a, longint b);
      logic signed [127:0] p;
      p = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
      return longint'(p >>> FRAC_BITS);
   endfunction

   // rate*sum / (n * 2^16), truncated toward zero and limited
   function automatic longint coef_step(longint sum, int unsigned n);
      logic signed [127:0] s;
      logic [127:0]        mag;
      logic [127:0]        q;
      s   = $signed({{64{sum[63]}}, sum});
      mag = (s < 0) ? -s : s;
      q   = (mag * 128'(rate_cfg)) / (128'(n) << FRAC_BITS);
      if (q > 128'(STEP_LIMIT))
         q = 128'(STEP_LIMIT);
      return (s < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
   endfunction

   function automatic longint coef_clamp(longint v);
      return (v > COEF_HI) ? COEF_HI : ((v < COEF_LO) ? COEF_LO : v);
   endfunction

   // run all epochs over the held samples
   function automatic fit_type fit_line(int unsigned n);
      longint slope;
      longint icpt;
      longint esum;
      longint wsum;
      longint err;
      logic signed [64:0] wide;
      fit_type f;
      slope = slope_start;
      icpt  = icpt_start;
      for (int e = 0; e < int'(epochs_cfg); e++) begin
         esum = 0;
         wsum = 0;
         for (int unsigned i = 0; i < n; i++) begin
            err  = y_held[i] - (q16_product(slope, x_held[i]) + icpt);
            esum = esum + err;
            if (esum > ESUM_HI) esum = ESUM_HI;
            if (esum < ESUM_LO) esum = ESUM_LO;
            wide = $signed({wsum[63], wsum}) + 65'(q16_product(err, x_held[i]));
            if (wide > 65'sh0_7FFF_FFFF_FFFF_FFFF)
               wsum = 64'sh7FFF_FFFF_FFFF_FFFF;
            else if (wide < -65'sh0_8000_0000_0000_0000)
               wsum = 64'sh8000_0000_0000_0000;
            else
               wsum = longint'(wide[63:0]);
         end
         icpt  = coef_clamp(icpt + coef_step(esum, n));
         slope = coef_clamp(slope + coef_step(wsum, n));
      end
      f.slope     = slope[FIELD_W-1:0];
      f.intercept = icpt[FIELD_W-1:0];
      return f;
   endfunction

   always @(posedge clock) begin
      fit_type got;
      fit_type want;
      if (reset) begin
         fit_q.delete();
         held_count   = 0;
         epochs_cfg   = EPOCH_RESET;
         rate_cfg     = RATE_RESET;
         slope_start  = 0;
         icpt_start   = 0;
         fail_count   = 0;
         fits_seen    = 0;
         fits_pending = 0;
      end else begin
         // mirror register writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_EPOCH_COUNT:    epochs_cfg  = csr_wdata[EPOCH_W-1:0];
               CSR_LEARNING_RATE:  rate_cfg    = csr_wdata[RATE_W-1:0];
               CSR_INIT_SLOPE:     slope_start = longint'($signed(csr_wdata));
               CSR_INIT_INTERCEPT: icpt_start  = longint'($signed(csr_wdata));
               default: ;
            endcase
         end
         // compare the returned word with the oldest prediction
         if (rsp_valid && rsp_ready) begin
            got.slope     = rsp_slope;
            got.intercept = rsp_intercept;
            fits_seen++;
            if (fit_q.size() == 0) begin
               $display("%0t: unexpected result word slope=%h intercept=%h",
                        $realtime, got.slope, got.intercept);
               fail_count++;
            end else begin
               want = fit_q.pop_front();
               if (got.slope !== want.slope) begin
                  $display("%0t: slope mismatch expected=%h actual=%h",
                           $realtime, want.slope, got.slope);
                  fail_count++;
               end
               if (got.intercept !== want.intercept) begin
                  $display("%0t: intercept mismatch expected=%h actual=%h",
                           $realtime, want.intercept, got.intercept);
                  fail_count++;
               end
            end
         end
         // store the sample word, drop it when full, train on the last one
         if (req_valid && req_ready) begin
            if (held_count < STORE_DEPTH) begin
               x_held[held_count] = longint'($signed(req_sample_x));
               y_held[held_count] = longint'($signed(req_sample_y));
               held_count++;
            end
            if (req_last_sample) begin
               fit_q.push_back(fit_line(held_count));
               held_count = 0;
            end
         end
         fits_pending = fit_q.size();
      end
   end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps

module tb
   import lrgd_pkg::*;
();

   localparam int                   QUIET_LIMIT  = 400000;
   localparam int                   ITEM_TARGET  = 1050;
   localparam int                   CALM_FROM    = 900;
   localparam logic [CSR_IDX_W-1:0] CSR_NO_REG   = 4'hF;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [FIELD_W-1:0]   req_sample_x;
   logic [FIELD_W-1:0]   req_sample_y;
   logic                 req_last_sample;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [FIELD_W-1:0]   rsp_slope;
   logic [FIELD_W-1:0]   rsp_intercept;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [FIELD_W-1:0]   csr_wdata;

   int   fail_count;
   int   fits_pending;
   int   fits_seen;
   int   samples_sent;
   int   sets_sent;
   int   quiet_cycles;
   bit   calm;
   bit   hold_rsp;

   linear_regression_gradient_descent DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_sample_x(req_sample_x), .req_sample_y(req_sample_y),
      .req_last_sample(req_last_sample),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_slope(rsp_slope), .rsp_intercept(rsp_intercept),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   tb_gd_checker fit_check (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_sample_x(req_sample_x), .req_sample_y(req_sample_y),
      .req_last_sample(req_last_sample),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_slope(rsp_slope), .rsp_intercept(rsp_intercept),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .fits_pending(fits_pending), .fits_seen(fits_seen)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // end the run when no word moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // result side: short random stalls, one long hold-off on request
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (2500) @(negedge clock);
            hold_rsp = 1'b0;
            rsp_ready <= 1'b1;
         end else if (!calm && !reset && $urandom_range(0, 6) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= !reset;
         end
      end
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [FIELD_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      forever begin
         @(posedge clock);
         if (csr_ready) break;
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // offer one sample word, sometimes with a random gap ahead of it
   task automatic push_sample(logic [FIELD_W-1:0] x, logic [FIELD_W-1:0] y, bit last);
      int gap;
      if (!calm && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 4);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid       <= 1'b1;
      req_sample_x    <= x;
      req_sample_y    <= y;
      req_last_sample <= last;
      forever begin
         @(posedge clock);
         if (req_ready) break;
      end
      samples_sent++;
      if (last) sets_sent++;
   endtask

   // drop valid and wait until every fit has come back
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (fits_pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic logic [FIELD_W-1:0] pick_q16();
      case ($urandom_range(0, 7))
         0:       return $urandom();
         1: begin
            case ($urandom_range(0, 3))
               0:       return 32'h7FFF_FFFF;
               1:       return 32'h8000_0000;
               2:       return 32'hFFFF_FFFF;
               default: return 32'h0;
            endcase
         end
         default: return 32'($urandom_range(0, 1048576)) - 32'd524288;
      endcase
   endfunction

   task automatic push_set(int count);
      for (int i = 1; i <= count; i++)
         push_sample(pick_q16(), pick_q16(), i == count);
   endtask

   // new random settings between phases
   task automatic shuffle_regs();
      if ($urandom_range(0, 1))
         write_reg(CSR_EPOCH_COUNT,
                   ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 4));
      if ($urandom_range(0, 1)) begin
         case ($urandom_range(0, 3))
            0:       write_reg(CSR_LEARNING_RATE, 32'd0);
            1:       write_reg(CSR_LEARNING_RATE, 32'hFFFF);
            default: write_reg(CSR_LEARNING_RATE, $urandom_range(0, 65535));
         endcase
      end
      if ($urandom_range(0, 2) == 0)
         write_reg(CSR_INIT_SLOPE, pick_q16());
      if ($urandom_range(0, 2) == 0)
         write_reg(CSR_INIT_INTERCEPT, pick_q16());
      if ($urandom_range(0, 9) == 0)
         write_reg(CSR_NO_REG, $urandom());
   endtask

   initial begin
      int set_len;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_sample_x    = '0;
      req_sample_y    = '0;
      req_last_sample = 1'b0;
      csr_valid       = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      samples_sent    = 0;
      sets_sent       = 0;
      quiet_cycles    = 0;
      calm            = 1'b0;
      hold_rsp        = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings on y = 2x + 1
      push_sample(32'h0001_0000, 32'h0003_0000, 1'b0);
      push_sample(32'h0002_0000, 32'h0005_0000, 1'b0);
      push_sample(32'h0003_0000, 32'h0007_0000, 1'b1);
      drain();

      // extreme settings and extreme samples
      write_reg(CSR_EPOCH_COUNT, 32'hFFFF);
      write_reg(CSR_LEARNING_RATE, 32'hFFFF);
      write_reg(CSR_INIT_SLOPE, 32'h7FFF_FFFF);
      write_reg(CSR_INIT_INTERCEPT, 32'h8000_0000);
      write_reg(CSR_EPOCH_COUNT, 32'd2);
      push_sample(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
      push_sample(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
      push_sample(32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
      drain();
      write_reg(CSR_INIT_SLOPE, 32'h8000_0000);
      write_reg(CSR_INIT_INTERCEPT, 32'h7FFF_FFFF);
      push_sample(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
      push_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
      drain();

      // zero epochs hands back the start values
      write_reg(CSR_EPOCH_COUNT, 32'd0);
      push_sample(32'h0001_0000, 32'h1234_5678, 1'b0);
      push_sample(32'hFFFF_0000, 32'h8765_4321, 1'b1);
      drain();

      // write to an unknown index must change nothing
      write_reg(CSR_EPOCH_COUNT, 32'd1);
      write_reg(CSR_LEARNING_RATE, 32'd0);
      write_reg(CSR_INIT_SLOPE, 32'h0000_8000);
      write_reg(CSR_INIT_INTERCEPT, 32'hFFFF_8000);
      write_reg(CSR_NO_REG, 32'hFFFF_FFFF);
      push_sample(32'h0004_0000, 32'h0002_0000, 1'b1);
      drain();

      // overfill the store: the extra word is dropped, training still runs
      write_reg(CSR_LEARNING_RATE, 32'd1311);
      for (int i = 0; i <= 256; i++)
         push_sample(pick_q16(), pick_q16(), i == 256);
      drain();

      // hold results off long enough that the input stalls
      write_reg(CSR_EPOCH_COUNT, 32'd2);
      hold_rsp = 1'b1;
      repeat (3) push_set(4);
      drain();

      // random phases
      while (samples_sent < ITEM_TARGET) begin
         if (samples_sent >= CALM_FROM) calm = 1'b1;
         shuffle_regs();
         repeat ($urandom_range(1, 5)) begin
            set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 8);
            push_set(set_len);
         end
         drain();
      end

      $display("covered %0d sample words in %0d training sets, %0d fits compared",
               samples_sent, sets_sent, fits_seen);
      $display("settings swept epochs 0..500, rate 0..65535, extreme start values");
      if (fail_count == 0 && fits_pending == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
